// File: design/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg - shared definitions for the segment/polygon crossing block
// Field widths fixed by the channel formats, request codes and the status
// struct passed from the edge tester to the controller.
// ----------------------------------------------------------------------------
package spc_pkg;

	// vertex_index and edge_index width
	localparam int unsigned IDX_W = 4;
	// vertex_count register width
	localparam int unsigned CNT_W = 5;

	// request codes
	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	// edge tester status toward the controller
	typedef struct packed {
		logic valid;  // a tested edge leaves the last stage
		logic meet;   // that edge touches the segment
		logic busy;   // some edge is still in flight
	} test_res_t;

endpackage

// File: design/spc_req_if.sv
// ----------------------------------------------------------------------------
// spc_req_if - request channel
// Vertex write or segment query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spc_req_if #(
	parameter int COORD_W = 17
) ();
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [spc_pkg::IDX_W-1:0]  vertex_index;
	logic [COORD_W-1:0]         vertex_x;
	logic [COORD_W-1:0]         vertex_y;
	logic [COORD_W-1:0]         seg_x1;
	logic [COORD_W-1:0]         seg_y1;
	logic [COORD_W-1:0]         seg_x2;
	logic [COORD_W-1:0]         seg_y2;

	modport source (
		output valid, req_type, vertex_index, vertex_x, vertex_y,
		       seg_x1, seg_y1, seg_x2, seg_y2,
		input  ready
	);
	modport sink (
		input  valid, req_type, vertex_index, vertex_x, vertex_y,
		       seg_x1, seg_y1, seg_x2, seg_y2,
		output ready
	);
endinterface

// File: design/spc_res_if.sv
// ----------------------------------------------------------------------------
// spc_res_if - result channel
// One crossing result per query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spc_res_if ();
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [spc_pkg::IDX_W-1:0]  edge_index;

	modport source (
		output valid, hit, edge_index,
		input  ready
	);
	modport sink (
		input  valid, hit, edge_index,
		output ready
	);
endinterface

// File: design/spc_cfg_if.sv
// ----------------------------------------------------------------------------
// spc_cfg_if - configuration write channel
// Carries the vertex_count register value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spc_cfg_if ();
	logic                       valid;
	logic                       ready;
	logic [spc_pkg::CNT_W-1:0]  vertex_count;

	modport source (
		output valid, vertex_count,
		input  ready
	);
	modport sink (
		input  valid, vertex_count,
		output ready
	);
endinterface

// File: design/spc_cell.sv
// ----------------------------------------------------------------------------
// spc_cell - one vertex slot of the rotating vertex ring
// Loads a vertex on a write transfer, otherwise takes its neighbor's vertex
// when the ring rotates.
// ----------------------------------------------------------------------------
module spc_cell #(
	parameter int COORD_W = 17
) (
	input  logic               clk,
	input  logic               load_en,
	input  logic               shift_en,
	input  logic [COORD_W-1:0] load_x,
	input  logic [COORD_W-1:0] load_y,
	input  logic [COORD_W-1:0] shift_x,
	input  logic [COORD_W-1:0] shift_y,
	output logic [COORD_W-1:0] x,
	output logic [COORD_W-1:0] y
);

	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;

	// vertex register: write has priority, never coincides with rotation
	always_ff @(posedge clk) begin
		if (load_en) begin
			x_q <= load_x;
			y_q <= load_y;
		end else if (shift_en) begin
			x_q <= shift_x;
			y_q <= shift_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

// File: design/spc_edge_test.sv
// ----------------------------------------------------------------------------
// spc_edge_test - pipelined segment versus edge test
// Three stages: coordinate differences and box checks, cross-product
// multiplies, product difference and sign. One edge enters per cycle.
// ----------------------------------------------------------------------------
module spc_edge_test #(
	parameter int COORD_W = 17,
	parameter int TAG_W   = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               issue_valid,
	input  logic [TAG_W-1:0]   tag_in,
	input  logic [COORD_W-1:0] e1x,
	input  logic [COORD_W-1:0] e1y,
	input  logic [COORD_W-1:0] e2x,
	input  logic [COORD_W-1:0] e2y,
	input  logic [COORD_W-1:0] s1x,
	input  logic [COORD_W-1:0] s1y,
	input  logic [COORD_W-1:0] s2x,
	input  logic [COORD_W-1:0] s2y,
	output spc_pkg::test_res_t res,
	output logic [TAG_W-1:0]   tag_out
);

	localparam int D_W = COORD_W + 1;  // signed coordinate difference
	localparam int P_W = 2 * D_W;      // product
	localparam int X_W = P_W + 1;      // cross product

	function automatic logic signed [D_W-1:0] diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	// q lies between a and b, inclusive
	function automatic logic between(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] q,
		input logic [COORD_W-1:0] b
	);
		return (q >= a && q <= b) || (q >= b && q <= a);
	endfunction

	logic                  valid_s1, valid_s2, valid_s3;
	logic [TAG_W-1:0]      tag_s1, tag_s2, tag_s3;
	logic [3:0]            box_s1, box_s2, box_s3;
	logic signed [D_W-1:0] ma_s1 [4];
	logic signed [D_W-1:0] mb_s1 [4];
	logic signed [D_W-1:0] na_s1 [4];
	logic signed [D_W-1:0] nb_s1 [4];
	logic signed [P_W-1:0] pa_s2 [4];
	logic signed [P_W-1:0] pb_s2 [4];
	logic [3:0]            pos_s3, neg_s3, zero_s3;

	logic signed [P_W-1:0] pa_c [4];
	logic signed [P_W-1:0] pb_c [4];
	logic signed [X_W-1:0] d_c  [4];

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= issue_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: differences; cross k is ma*mb - na*nb
	always_ff @(posedge clk) begin
		tag_s1   <= tag_in;
		ma_s1[0] <= diff(e2x, e1x); mb_s1[0] <= diff(s1y, e1y);
		na_s1[0] <= diff(e2y, e1y); nb_s1[0] <= diff(s1x, e1x);
		ma_s1[1] <= diff(e2x, e1x); mb_s1[1] <= diff(s2y, e1y);
		na_s1[1] <= diff(e2y, e1y); nb_s1[1] <= diff(s2x, e1x);
		ma_s1[2] <= diff(s2x, s1x); mb_s1[2] <= diff(e1y, s1y);
		na_s1[2] <= diff(s2y, s1y); nb_s1[2] <= diff(e1x, s1x);
		ma_s1[3] <= diff(s2x, s1x); mb_s1[3] <= diff(e2y, s1y);
		na_s1[3] <= diff(s2y, s1y); nb_s1[3] <= diff(e2x, s1x);
		box_s1[0] <= between(e1x, s1x, e2x) && between(e1y, s1y, e2y);
		box_s1[1] <= between(e1x, s2x, e2x) && between(e1y, s2y, e2y);
		box_s1[2] <= between(s1x, e1x, s2x) && between(s1y, e1y, s2y);
		box_s1[3] <= between(s1x, e2x, s2x) && between(s1y, e2y, s2y);
	end

	// stage 2: products
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pa_c[k] = ma_s1[k] * mb_s1[k];
			pb_c[k] = na_s1[k] * nb_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		box_s2 <= box_s1;
		for (int k = 0; k < 4; k++) begin
			pa_s2[k] <= pa_c[k];
			pb_s2[k] <= pb_c[k];
		end
	end

	// stage 3: cross products and their signs
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			d_c[k] = pa_s2[k] - pb_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= tag_s2;
		box_s3 <= box_s2;
		for (int k = 0; k < 4; k++) begin
			zero_s3[k] <= (d_c[k] == '0);
			neg_s3[k]  <= d_c[k][X_W-1];
			pos_s3[k]  <= !d_c[k][X_W-1] && (d_c[k] != '0);
		end
	end

	// proper crossing, or a collinear endpoint inside the other box
	always_comb begin
		res.valid = valid_s3;
		res.busy  = valid_s1 || valid_s2 || valid_s3;
		res.meet  = (((pos_s3[0] && neg_s3[1]) || (neg_s3[0] && pos_s3[1])) &&
		             ((pos_s3[2] && neg_s3[3]) || (neg_s3[2] && pos_s3[3]))) ||
		            (|(zero_s3 & box_s3));
	end

	assign tag_out = tag_s3;

endmodule

// File: design/segment_polygon_crossing.sv
// ----------------------------------------------------------------------------
// segment_polygon_crossing - line segment versus closed polygon test
// Holds one polygon in a ring of vertex cells and reports the first edge a
// query segment touches or crosses.
// ----------------------------------------------------------------------------
// Usage:
//   cfg : writes vertex_count (clamped to MAX_VERTICES at use); always ready.
//   req : req_type 0 stores (vertex_x, vertex_y) at vertex_index, no
//         result; slots at or above MAX_VERTICES are dropped.
//         req_type 1 queries segment (seg_x1,seg_y1)-(seg_x2,seg_y2).
//   res : one transfer per query: hit and the first edge hit (0 if none).
// Timing:
//   A query rotates the vertex ring one position per cycle, feeding one
//   edge per cycle into a three-stage cross-product tester; its result
//   is registered in the output register. req is ready only while no
//   query is in progress, so queries run one after another.
// Reset: clears vertex_count and all control; vertex slots hold garbage
//   until written.
// Stall: a finished result waits in the output register; a new item is
//   accepted meanwhile, and the following result waits until it is taken.
// ----------------------------------------------------------------------------
module segment_polygon_crossing #(
	parameter int MAX_VERTICES = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	spc_cfg_if.sink   cfg,
	spc_req_if.sink   req,
	spc_res_if.source res
);

	localparam int COORD_W = FRAC_BITS + 1;
	localparam int J_W     = $clog2(MAX_VERTICES);
	localparam int R_W     = $clog2(MAX_VERTICES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                     state_q;
	logic [spc_pkg::CNT_W-1:0]  vertex_count_q;
	logic [R_W-1:0]             n_q;
	logic [R_W-1:0]             cnt_q;
	logic [COORD_W-1:0]         s1x_q, s1y_q, s2x_q, s2y_q;
	logic [COORD_W-1:0]         first_x_q, first_y_q;
	logic                       found_q;
	logic [J_W-1:0]             hit_j_q;
	logic                       out_valid_q;
	logic                       out_hit_q;
	logic [spc_pkg::IDX_W-1:0]  out_edge_q;

	logic [COORD_W-1:0]         cell_x [MAX_VERTICES];
	logic [COORD_W-1:0]         cell_y [MAX_VERTICES];
	logic [8:0]                 count_ext;
	logic [R_W-1:0]             n_lim;
	logic [7:0]                 hit_j_ext;
	logic                       wr_en, query_go, shift_en, issue_valid, last_edge;
	logic                       out_free;
	logic [COORD_W-1:0]         e2x, e2y;
	spc_pkg::test_res_t         tres;
	logic [J_W-1:0]             tag_out;

	// handshakes
	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign wr_en     = req.valid && req.ready && (req.req_type == spc_pkg::REQ_WRITE);
	assign query_go  = req.valid && req.ready && (req.req_type == spc_pkg::REQ_QUERY);
	assign out_free  = !out_valid_q || res.ready;

	// edge count in use, clamped to the ring size
	assign count_ext = 9'(vertex_count_q);
	assign n_lim     = (count_ext > 9'(MAX_VERTICES)) ? R_W'(MAX_VERTICES)
	                                                   : R_W'(vertex_count_q);

	// ring rotation and edge issue; fewer than two vertices issue no edge
	assign shift_en    = (state_q == ST_RUN) && (cnt_q != R_W'(MAX_VERTICES));
	assign issue_valid = (state_q == ST_RUN) && (n_q > R_W'(1)) && (cnt_q < n_q);
	assign last_edge   = (cnt_q == n_q - R_W'(1));
	assign e2x         = last_edge ? first_x_q : cell_x[1];
	assign e2y         = last_edge ? first_y_q : cell_y[1];

	// vertex ring: cell i takes the vertex of cell i+1 on rotation
	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		spc_cell #(
			.COORD_W (COORD_W)
		) u_cell (
			.clk      (clk),
			.load_en  (wr_en && (9'(req.vertex_index) == 9'(i))),
			.shift_en (shift_en),
			.load_x   (req.vertex_x),
			.load_y   (req.vertex_y),
			.shift_x  (cell_x[(i + 1) % MAX_VERTICES]),
			.shift_y  (cell_y[(i + 1) % MAX_VERTICES]),
			.x        (cell_x[i]),
			.y        (cell_y[i])
		);
	end

	spc_edge_test #(
		.COORD_W (COORD_W),
		.TAG_W   (J_W)
	) u_test (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue_valid (issue_valid),
		.tag_in      (cnt_q[J_W-1:0]),
		.e1x         (cell_x[0]),
		.e1y         (cell_y[0]),
		.e2x         (e2x),
		.e2y         (e2y),
		.s1x         (s1x_q),
		.s1y         (s1y_q),
		.s2x         (s2x_q),
		.s2y         (s2y_q),
		.res         (tres),
		.tag_out     (tag_out)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	// query sequencer and first-hit capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
			found_q <= 1'b0;
			hit_j_q <= '0;
		end else begin
			if (shift_en) begin
				cnt_q <= cnt_q + R_W'(1);
			end
			if (tres.valid && tres.meet && !found_q) begin
				found_q <= 1'b1;
				hit_j_q <= tag_out;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_go) begin
						cnt_q   <= '0;
						n_q     <= n_lim;
						found_q <= 1'b0;
						hit_j_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!shift_en && !tres.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query payload: segment and vertex 0 for the closing edge
	always_ff @(posedge clk) begin
		if (query_go) begin
			s1x_q     <= req.seg_x1;
			s1y_q     <= req.seg_y1;
			s2x_q     <= req.seg_x2;
			s2y_q     <= req.seg_y2;
			first_x_q <= cell_x[0];
			first_y_q <= cell_y[0];
		end
	end

	// output register
	assign hit_j_ext = 8'(hit_j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_hit_q  <= found_q;
			out_edge_q <= hit_j_ext[spc_pkg::IDX_W-1:0];
		end
	end

	assign res.valid      = out_valid_q;
	assign res.hit        = out_hit_q;
	assign res.edge_index = out_edge_q;

endmodule
